@@ src/erg_pkg.sv @@
// Package for the Euclidean rhythm generator: item structs, sequencer states
// and the control/status structs between sequencer and datapath. No dependencies.
package erg_pkg;

   localparam int STEP_W = 7;
   localparam int PAT_W  = 64;

   typedef struct packed {
      logic [STEP_W-1:0] steps;
      logic [STEP_W-1:0] pulses;
   } req_type;

   typedef struct packed {
      logic [PAT_W-1:0]  pattern;
      logic [STEP_W-1:0] pattern_length;
      logic              bad_request;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHAIN,
      ST_REV,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;     // take a new item
      logic step;     // one subtraction, append the current group
      logic lvl_end;  // close a level of the chain
      logic rev;      // reverse the built pattern
      logic shr;      // shift toward the first onset
   } ctrl_type;

   typedef struct packed {
      logic skip;     // item needs no build (bad or no pulses)
      logic ge;       // dividend still covers the divisor
      logic top;      // working on the last level
      logic bit0;     // lowest pattern bit is an onset
   } stat_type;

endpackage

@@ src/erg_ctrl.sv @@
// Sequencer of the Euclidean rhythm generator.
// Depends on erg_pkg.
module erg_ctrl import erg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     busy,
   output logic     done
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = stat.skip ? ST_DONE : ST_CHAIN;
            end
         end
         ST_CHAIN: begin
            if (stat.ge) begin
               ctrl.step = 1'b1;
            end else begin
               ctrl.lvl_end = 1'b1;
               if (stat.top) begin
                  state_in = ST_REV;
               end
            end
         end
         ST_REV: begin
            ctrl.rev = 1'b1;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (stat.bit0) begin
               state_in = ST_DONE;
            end else begin
               ctrl.shr = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

endmodule

@@ src/erg_datapath.sv @@
// Datapath of the Euclidean rhythm generator: one subtract/compare unit for
// the quotient chain and shifters that append groups and align the result.
// Depends on erg_pkg.
module erg_datapath import erg_pkg::*; #(
   parameter int MAX_STEPS = 64
) (
   input  logic     clock,
   input  req_type  req,
   input  ctrl_type ctrl,
   output stat_type stat,
   output rsp_type  rsp
);

   logic [STEP_W-1:0]    div_ff, div_in, d_ff, d_in, n_ff, n_in;
   logic [STEP_W-1:0]    alen_ff, alen_in, blen_ff, blen_in, slen_ff, slen_in;
   logic [MAX_STEPS-1:0] a_ff, a_in, b_ff, b_in, s_ff, s_in;
   logic                 top_ff, top_in, bad_ff, bad_in;
   logic [STEP_W-1:0]    lim;
   logic [MAX_STEPS-1:0] s_with_a, s_with_b, rv;
   logic                 bad_now;

   assign bad_now = (req.steps == '0) || (req.steps > STEP_W'(MAX_STEPS)) ||
                    (req.pulses > req.steps);

   // On the last level the count itself is the number of groups left.
   assign lim      = top_ff ? STEP_W'(1) : d_ff;
   assign s_with_a = s_ff | (a_ff << slen_ff);
   assign s_with_b = s_ff | (b_ff << slen_ff);

   always_comb begin
      for (int i = 0; i < MAX_STEPS; i++) begin
         rv[i] = s_ff[MAX_STEPS-1-i];
      end
   end

   always_comb begin
      div_in  = div_ff;
      d_in    = d_ff;
      n_in    = n_ff;
      alen_in = alen_ff;
      blen_in = blen_ff;
      slen_in = slen_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      s_in    = s_ff;
      top_in  = top_ff;
      bad_in  = bad_ff;
      if (ctrl.load) begin
         n_in    = req.steps;
         bad_in  = bad_now;
         div_in  = req.steps - req.pulses;
         d_in    = req.pulses;
         a_in    = '0;
         b_in    = MAX_STEPS'(1);
         alen_in = STEP_W'(1);
         blen_in = STEP_W'(1);
         s_in    = '0;
         slen_in = '0;
         top_in  = 1'b0;
      end else if (ctrl.step) begin
         div_in  = div_ff - lim;
         s_in    = s_with_a;
         slen_in = slen_ff + alen_ff;
      end else if (ctrl.lvl_end) begin
         if (top_ff) begin
            if (d_ff != '0) begin
               s_in    = s_with_b;
               slen_in = slen_ff + blen_ff;
            end
         end else begin
            // The remainder becomes the next divisor; the new group is S then B.
            a_in    = s_with_b;
            alen_in = slen_ff + blen_ff;
            b_in    = a_ff;
            blen_in = alen_ff;
            s_in    = '0;
            slen_in = '0;
            div_in  = d_ff;
            d_in    = div_ff;
            top_in  = (div_ff <= STEP_W'(1));
         end
      end else if (ctrl.rev) begin
         s_in = rv >> (STEP_W'(MAX_STEPS) - n_ff);
      end else if (ctrl.shr) begin
         s_in = s_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      d_ff    <= d_in;
      n_ff    <= n_in;
      alen_ff <= alen_in;
      blen_ff <= blen_in;
      slen_ff <= slen_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      s_ff    <= s_in;
      top_ff  <= top_in;
      bad_ff  <= bad_in;
   end

   assign stat.skip = bad_now || (req.pulses == '0);
   assign stat.ge   = (div_ff >= lim);
   assign stat.top  = top_ff;
   assign stat.bit0 = s_ff[0];

   assign rsp.pattern        = PAT_W'(s_ff);
   assign rsp.pattern_length = n_ff;
   assign rsp.bad_request    = bad_ff;

endmodule

@@ src/euclidean_rhythm_generator_top.sv @@
// Top level of the Euclidean rhythm generator.
// Depends on erg_pkg, erg_ctrl and erg_datapath.
//
//   channel  | ports                    | handshake
//   request  | start, busy, req_data    | taken when start is high and busy is low
//   response | rsp_valid, rsp_data      | one-cycle strobe, always taken
//
// After acceptance an item runs through the quotient chain, one subtraction per quotient
// and one level close per chain level, then the reversal of the built pattern and the
// one-bit alignment shifts past the leading zero steps of the reversed pattern. The chain
// has a single subtractor. Bad or zero-pulse items show their result in the cycle after
// acceptance. Reset is synchronous and returns the sequencer to idle; the receiver
// cannot stall, and busy stays high through the result cycle.
module euclidean_rhythm_generator_top import erg_pkg::*; #(
   parameter int MAX_STEPS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctrl_type ctrl;
   stat_type stat;
   logic     start_ok;

   assign start_ok = start && !busy;

   erg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start_ok),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy),
      .done  (rsp_valid)
   );

   erg_datapath #(.MAX_STEPS(MAX_STEPS)) u_dp (
      .clock (clock),
      .req   (req_data),
      .ctrl  (ctrl),
      .stat  (stat),
      .rsp   (rsp_data)
   );

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start_ok |=> busy) else $error("busy did not rise after an item");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_request |-> rsp_data.pattern == '0)
      else $error("bad item with nonzero pattern");

endmodule
